FILE: hw/rtl/bbc_pkg.sv
package bbc_pkg;

   // request kinds
   localparam logic [2:0] KIND_GET_LOAD   = 3'd0;
   localparam logic [2:0] KIND_GET_ZERO   = 3'd1;
   localparam logic [2:0] KIND_FIND       = 3'd2;
   localparam logic [2:0] KIND_PUT        = 3'd3;
   localparam logic [2:0] KIND_INVALIDATE = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_RANGE     = 3'd2;
   localparam logic [2:0] ST_BUSY      = 3'd3;
   localparam logic [2:0] ST_NO_SLOT   = 3'd4;
   localparam logic [2:0] ST_NOT_BUSY  = 3'd5;

   localparam int KIND_W     = 3;
   localparam int BLOCK_W    = 32;
   localparam int SLOT_W     = 6;
   localparam int DROP_W     = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;

   // order chain command, broadcast to every cell
   typedef struct packed {
      logic remove;
      logic append;
      logic drop_lru;
   } chain_cmd_type;

   // per-slot state update
   typedef struct packed {
      logic alloc;
      logic grant;
      logic release_slot;
      logic drop;
      logic set_dirty;
   } slot_cmd_type;

endpackage

FILE: hw/rtl/bbc_slot_cell.sv
// one slot: tag, valid, busy, dirty; compares its tag against the lookup
module bbc_slot_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  bbc_pkg::slot_cmd_type         cmd,
   input  logic [bbc_pkg::BLOCK_W-1:0]   lookup_block,
   input  logic [bbc_pkg::BLOCK_W-1:0]   new_tag,
   output logic                          match,
   output logic                          busy,
   output logic                          dirty,
   output logic [bbc_pkg::BLOCK_W-1:0]   tag
);

   logic                        valid_ff, valid_in;
   logic                        busy_ff, busy_in;
   logic                        dirty_ff, dirty_in;
   logic [bbc_pkg::BLOCK_W-1:0] tag_ff, tag_in;

   always_comb begin
      valid_in = valid_ff;
      busy_in  = busy_ff;
      dirty_in = dirty_ff;
      tag_in   = tag_ff;
      if (cmd.alloc) begin
         tag_in   = new_tag;
         valid_in = 1'b1;
         busy_in  = 1'b1;
         dirty_in = dirty_ff | cmd.set_dirty;
      end
      if (cmd.grant) begin
         busy_in  = 1'b1;
         dirty_in = dirty_ff | cmd.set_dirty;
      end
      if (cmd.release_slot) begin
         busy_in  = 1'b0;
         dirty_in = 1'b0;
      end
      // idle valid slots sit in the LRU list and are dropped
      if (cmd.drop) begin
         valid_in = valid_ff & busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         dirty_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         dirty_ff <= dirty_in;
      end
      tag_ff <= tag_in;
   end

   assign match = valid_ff && (tag_ff == lookup_block);
   assign busy  = busy_ff;
   assign dirty = dirty_ff;
   assign tag   = tag_ff;

endmodule

FILE: hw/rtl/bbc_order_cell.sv
// one place of the order chain: free entries first, then LRU oldest to newest
module bbc_order_cell #(
   parameter int IDX_W      = 6,
   parameter int CELL_INDEX = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bbc_pkg::chain_cmd_type cmd,
   input  logic [IDX_W-1:0]       key,
   input  logic [IDX_W-1:0]       new_idx,
   input  logic                   shift_in,
   input  logic                   left_occ,
   input  logic                   right_occ,
   input  logic [IDX_W-1:0]       right_idx,
   input  logic                   right_lru,
   output logic                   shift_out,
   output logic                   occ,
   output logic [IDX_W-1:0]       idx,
   output logic                   lru
);

   logic             occ_ff, occ_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             lru_ff, lru_in;
   logic             match;

   assign match     = cmd.remove && occ_ff && (idx_ff == key);
   assign shift_out = match | shift_in;

   always_comb begin
      occ_in = occ_ff;
      idx_in = idx_ff;
      lru_in = lru_ff;
      if (shift_out) begin
         occ_in = right_occ;
         idx_in = right_idx;
         lru_in = right_lru;
      end else if (cmd.append && !occ_ff && left_occ) begin
         occ_in = 1'b1;
         idx_in = new_idx;
         lru_in = 1'b1;
      end
      if (cmd.drop_lru) begin
         lru_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b1;
         idx_ff <= IDX_W'(CELL_INDEX);
         lru_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
         idx_ff <= idx_in;
         lru_ff <= lru_in;
      end
   end

   assign occ = occ_ff;
   assign idx = idx_ff;
   assign lru = lru_ff;

endmodule

FILE: hw/rtl/block_buffer_cache_tags.sv
// Tag and policy engine of a disk block buffer cache.
// req_ channel: one request word per transfer, kind in req_tuser.
// rsp_ channel: exactly one result word per request, in request order.
// csr_: write max_block (block numbers at or above it are rejected) only
// while no request is in flight.
// Timing: when a request is taken, its tag compare result is registered
// with it in the holding stage; once the result register is free, the
// held request is resolved, the slot cells and the order chain are
// updated, and the result register is loaded, raising rsp_tvalid. The
// single request holding stage takes no new request until the held one
// has been processed. On invalidate the whole LRU part of the chain is
// relabeled free at once.
// The order chain is a row of SLOT_COUNT cells holding slot numbers: free
// ring entries first, LRU entries after them, oldest first. Removing an
// entry shifts every cell behind it one place forward.
// A stalled result register holds its word; the holding stage waits for it,
// so req_tready drops until the result is taken.
// Reset: all slots free in order 0..SLOT_COUNT-1, none valid, none busy,
// max_block all ones; no clearing pass, ready right after reset.
module block_buffer_cache_tags #(
   parameter int SLOT_COUNT = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // block_number[31:0], slot[37:32], mark_dirty[38], zero pad
   input  logic [bbc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // kind[2:0]
   input  logic [bbc_pkg::KIND_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[2:0], granted_slot[8:3], hit[9], fetch_request[10],
   // zero_request[11], writeback_request[12], writeback_block[44:13],
   // dropped_count[51:45], zero pad
   output logic [bbc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [bbc_pkg::BLOCK_W-1:0]     csr_wr_data
);

   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int WIDE_W = IDX_W + bbc_pkg::SLOT_W;

   // config
   logic [bbc_pkg::BLOCK_W-1:0] max_block_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_block_ff <= '1;
      end else if (csr_wr_en) begin
         max_block_ff <= csr_wr_data;
      end
   end

   // request fields
   logic [bbc_pkg::BLOCK_W-1:0] req_block;
   logic [bbc_pkg::SLOT_W-1:0]  req_slot;
   logic                        req_mdirty;
   logic [WIDE_W-1:0]           req_slot_wide;

   assign req_block     = req_tdata[31:0];
   assign req_slot      = req_tdata[37:32];
   assign req_mdirty    = req_tdata[38];
   assign req_slot_wide = {{IDX_W{1'b0}}, req_slot};

   // slot cells
   bbc_pkg::slot_cmd_type       slot_cmd  [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]       slot_match;
   logic [SLOT_COUNT-1:0]       slot_busy;
   logic [SLOT_COUNT-1:0]       slot_dirty;
   logic [bbc_pkg::BLOCK_W-1:0] slot_tag  [SLOT_COUNT];

   // order chain
   bbc_pkg::chain_cmd_type chain_cmd;
   logic [IDX_W-1:0]       chain_key;
   logic [IDX_W-1:0]       chain_new_idx;
   logic                   cell_occ   [SLOT_COUNT];
   logic [IDX_W-1:0]       cell_idx   [SLOT_COUNT];
   logic                   cell_lru   [SLOT_COUNT];
   logic                   cell_shift [SLOT_COUNT];

   // holding stage
   logic                        busy_ff;
   logic [bbc_pkg::KIND_W-1:0]  kind_ff;
   logic [bbc_pkg::BLOCK_W-1:0] block_ff;
   logic [IDX_W-1:0]            put_idx_ff;
   logic                        put_oob_ff;
   logic                        mdirty_ff;
   logic                        range_ff;
   logic [SLOT_COUNT-1:0]       hitv_ff;
   logic                        put_busy_ff;
   logic                        put_dirty_ff;
   logic [bbc_pkg::BLOCK_W-1:0] put_tag_ff;

   logic                        fire;
   logic                        accept;

   logic [CNT_W-1:0]            free_count_ff, free_count_in;
   logic [CNT_W-1:0]            lru_count_ff, lru_count_in;

   logic                        rsp_valid_ff;
   logic [bbc_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && !busy_ff;
   assign fire       = busy_ff && (!rsp_valid_ff || rsp_tready);

   // put slot lookup done at accept time; state is quiet until processing
   logic                        sel_busy;
   logic                        sel_dirty;
   logic [bbc_pkg::BLOCK_W-1:0] sel_tag;

   always_comb begin
      sel_busy  = 1'b0;
      sel_dirty = 1'b0;
      sel_tag   = '0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (req_slot_wide == WIDE_W'(i)) begin
            sel_busy  = sel_busy | slot_busy[i];
            sel_dirty = sel_dirty | slot_dirty[i];
            sel_tag   = sel_tag | slot_tag[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (accept) begin
         busy_ff <= 1'b1;
      end else if (fire) begin
         busy_ff <= 1'b0;
      end
      if (accept) begin
         kind_ff      <= req_tuser;
         block_ff     <= req_block;
         put_idx_ff   <= req_slot_wide[IDX_W-1:0];
         put_oob_ff   <= req_slot_wide >= WIDE_W'(SLOT_COUNT);
         mdirty_ff    <= req_mdirty;
         range_ff     <= req_block >= max_block_ff;
         hitv_ff      <= slot_match;
         put_busy_ff  <= sel_busy;
         put_dirty_ff <= sel_dirty;
         put_tag_ff   <= sel_tag;
      end
   end

   // resolve the held request
   logic [IDX_W-1:0]            hit_idx;
   logic                        found;
   logic                        hit_busy;
   logic [2:0]                  status;
   logic [IDX_W-1:0]            granted;
   logic                        hit_flag;
   logic                        fetch;
   logic                        zero;
   logic                        wb;
   logic [bbc_pkg::BLOCK_W-1:0] wb_block;
   logic                        drop_all;
   logic                        do_alloc;
   logic                        do_grant;
   logic                        do_release;
   logic [IDX_W-1:0]            target;
   logic [IDX_W+bbc_pkg::SLOT_W-1:0] granted_wide;
   logic [CNT_W+bbc_pkg::DROP_W-1:0] dropped_wide;

   always_comb begin
      hit_idx  = '0;
      hit_busy = 1'b0;
      for (int i = 0; i < SLOT_COUNT; i++) begin
         if (hitv_ff[i]) begin
            hit_idx  = hit_idx | IDX_W'(i);
            hit_busy = hit_busy | slot_busy[i];
         end
      end
      found = |hitv_ff;
   end

   always_comb begin
      status        = bbc_pkg::ST_OK;
      granted       = '0;
      hit_flag      = 1'b0;
      fetch         = 1'b0;
      zero          = 1'b0;
      wb            = 1'b0;
      wb_block      = '0;
      drop_all      = 1'b0;
      do_alloc      = 1'b0;
      do_grant      = 1'b0;
      do_release    = 1'b0;
      target        = '0;
      chain_cmd     = '0;
      chain_key     = '0;
      chain_new_idx = put_idx_ff;
      free_count_in = free_count_ff;
      lru_count_in  = lru_count_ff;
      case (kind_ff)
         bbc_pkg::KIND_GET_LOAD, bbc_pkg::KIND_GET_ZERO, bbc_pkg::KIND_FIND: begin
            if (range_ff) begin
               status = bbc_pkg::ST_RANGE;
            end else if (found) begin
               if (hit_busy) begin
                  status = bbc_pkg::ST_BUSY;
               end else begin
                  // idle valid slot lives in the LRU part
                  do_grant         = 1'b1;
                  target           = hit_idx;
                  chain_cmd.remove = 1'b1;
                  chain_key        = hit_idx;
                  lru_count_in     = lru_count_ff - CNT_W'(1);
                  hit_flag         = 1'b1;
                  granted          = hit_idx;
                  zero             = (kind_ff == bbc_pkg::KIND_GET_ZERO);
               end
            end else if (kind_ff == bbc_pkg::KIND_FIND) begin
               status = bbc_pkg::ST_NOT_FOUND;
            end else if (free_count_ff != '0 || lru_count_ff != '0) begin
               // free head, or LRU oldest when no free entry: chain front
               do_alloc         = 1'b1;
               target           = cell_idx[0];
               chain_cmd.remove = 1'b1;
               chain_key        = cell_idx[0];
               if (free_count_ff != '0) begin
                  free_count_in = free_count_ff - CNT_W'(1);
               end else begin
                  lru_count_in = lru_count_ff - CNT_W'(1);
               end
               granted = cell_idx[0];
               zero    = (kind_ff == bbc_pkg::KIND_GET_ZERO);
               fetch   = (kind_ff == bbc_pkg::KIND_GET_LOAD);
            end else begin
               status = bbc_pkg::ST_NO_SLOT;
            end
         end
         bbc_pkg::KIND_PUT: begin
            if (put_oob_ff || !put_busy_ff) begin
               status = bbc_pkg::ST_NOT_BUSY;
            end else begin
               wb = mdirty_ff | put_dirty_ff;
               if (wb) begin
                  wb_block = put_tag_ff;
               end
               do_release       = 1'b1;
               target           = put_idx_ff;
               chain_cmd.append = 1'b1;
               lru_count_in     = lru_count_ff + CNT_W'(1);
            end
         end
         bbc_pkg::KIND_INVALIDATE: begin
            drop_all           = 1'b1;
            chain_cmd.drop_lru = 1'b1;
            free_count_in      = free_count_ff + lru_count_ff;
            lru_count_in       = '0;
         end
         default: begin
         end
      endcase
      if (!fire) begin
         chain_cmd     = '0;
         drop_all      = 1'b0;
         do_alloc      = 1'b0;
         do_grant      = 1'b0;
         do_release    = 1'b0;
         free_count_in = free_count_ff;
         lru_count_in  = lru_count_ff;
      end
   end

   assign granted_wide = {{bbc_pkg::SLOT_W{1'b0}}, granted};
   assign dropped_wide = {{bbc_pkg::DROP_W{1'b0}}, (drop_all ? lru_count_ff : CNT_W'(0))};

   always_ff @(posedge clock) begin
      if (reset) begin
         free_count_ff <= CNT_W'(SLOT_COUNT);
         lru_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         free_count_ff <= free_count_in;
         lru_count_ff  <= lru_count_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         rsp_data_ff <= {4'd0, dropped_wide[bbc_pkg::DROP_W-1:0], wb_block, wb, zero,
                         fetch, hit_flag, granted_wide[bbc_pkg::SLOT_W-1:0], status};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // cells
   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
      assign slot_cmd[g] = '{alloc:        do_alloc && (target == IDX_W'(g)),
                             grant:        do_grant && (target == IDX_W'(g)),
                             release_slot: do_release && (target == IDX_W'(g)),
                             drop:         drop_all,
                             set_dirty:    zero};

      bbc_slot_cell u_slot (
         .clock        (clock),
         .reset        (reset),
         .cmd          (slot_cmd[g]),
         .lookup_block (req_block),
         .new_tag      (block_ff),
         .match        (slot_match[g]),
         .busy         (slot_busy[g]),
         .dirty        (slot_dirty[g]),
         .tag          (slot_tag[g])
      );
   end

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_order
      logic             sh_in;
      logic             l_occ;
      logic             r_occ;
      logic [IDX_W-1:0] r_idx;
      logic             r_lru;

      if (g == 0) begin : g_first
         assign sh_in = 1'b0;
         assign l_occ = 1'b1;
      end else begin : g_mid
         assign sh_in = cell_shift[g-1];
         assign l_occ = cell_occ[g-1];
      end
      if (g == SLOT_COUNT - 1) begin : g_last
         assign r_occ = 1'b0;
         assign r_idx = '0;
         assign r_lru = 1'b0;
      end else begin : g_inner
         assign r_occ = cell_occ[g+1];
         assign r_idx = cell_idx[g+1];
         assign r_lru = cell_lru[g+1];
      end

      bbc_order_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (chain_cmd),
         .key       (chain_key),
         .new_idx   (chain_new_idx),
         .shift_in  (sh_in),
         .left_occ  (l_occ),
         .right_occ (r_occ),
         .right_idx (r_idx),
         .right_lru (r_lru),
         .shift_out (cell_shift[g]),
         .occ       (cell_occ[g]),
         .idx       (cell_idx[g]),
         .lru       (cell_lru[g])
      );
   end

   // tags of valid slots are unique, so a lookup hits at most one slot
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> $onehot0(hitv_ff))
      else $error("lookup hit more than one slot");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, free_count_ff} + {1'b0, lru_count_ff}) <= (CNT_W + 1)'(SLOT_COUNT))
      else $error("free and LRU counts exceed slot count");

   a_inval_empties: assert property (@(posedge clock) disable iff (reset)
      (fire && kind_ff == bbc_pkg::KIND_INVALIDATE) |=> (lru_count_ff == '0))
      else $error("LRU list not empty after invalidate");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid && !busy_ff)
      else $error("processed request left no result");

endmodule

FILE: verif/block_buffer_cache_tags_test.sv
module block_buffer_cache_tags_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = 64;
   localparam int LIMIT = 400000;

   // one request word: kind rides in tuser, the rest in tdata
   typedef struct {
      logic [2:0]  kind;
      logic [31:0] bno;
      logic [5:0]  slot;
      logic        mdirty;
   } req_word_type;

   // one result word, fields as unpacked from rsp_tdata
   typedef struct {
      logic [2:0]  status;
      logic [5:0]  granted;
      logic        hit;
      logic        fetch;
      logic        zero;
      logic        wb;
      logic [31:0] wb_block;
      logic [6:0]  dropped;
   } rsp_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [bbc_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [bbc_pkg::KIND_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [bbc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [bbc_pkg::BLOCK_W-1:0] csr_wr_data = '0;

   block_buffer_cache_tags #(.SLOT_COUNT(NSLOT)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------- cache shadow (predictor state) ----------------
   logic [31:0] lim_block;
   logic [31:0] tag_q   [NSLOT];
   logic        valid_q [NSLOT];
   logic        busy_q  [NSLOT];
   logic        dirty_q [NSLOT];
   int          free_q  [$];   // free ring, head first
   int          lru_q   [$];   // LRU list, oldest first

   req_word_type pending_reqs [$];
   rsp_word_type expected_rsps [$];
   int  fails = 0;
   int  cycles = 0;
   bit  gate = 1'b0;       // initial block holds driver off while set
   bit  stim_done = 1'b0;

   function automatic void shadow_reset();
      lim_block = 32'hFFFF_FFFF;
      free_q = {};
      lru_q = {};
      for (int i = 0; i < NSLOT; i++) begin
         tag_q[i] = '0; valid_q[i] = 1'b0; busy_q[i] = 1'b0; dirty_q[i] = 1'b0;
         free_q.push_back(i);
      end
   endfunction

   function automatic void lru_drop(int s);
      for (int i = 0; i < lru_q.size(); i++)
         if (lru_q[i] == s) begin
            lru_q.delete(i);
            break;
         end
   endfunction

   // compute the result of one request and advance the shadow
   function automatic rsp_word_type cache_predict(req_word_type r);
      rsp_word_type o;
      int s;
      bit found;
      o = '{default: '0};
      found = 0;
      s = 0;
      if (r.kind == bbc_pkg::KIND_GET_LOAD || r.kind == bbc_pkg::KIND_GET_ZERO ||
          r.kind == bbc_pkg::KIND_FIND) begin
         if (r.bno >= lim_block) o.status = bbc_pkg::ST_RANGE;
         else begin
            for (int i = 0; i < NSLOT; i++)
               if (valid_q[i] && tag_q[i] == r.bno) begin
                  found = 1; s = i; break;
               end
            if (found) begin
               if (busy_q[s]) o.status = bbc_pkg::ST_BUSY;
               else begin
                  if (r.kind == bbc_pkg::KIND_GET_ZERO) begin
                     dirty_q[s] = 1'b1; o.zero = 1'b1;
                  end
                  lru_drop(s);
                  busy_q[s] = 1'b1; o.hit = 1'b1; o.granted = 6'(s);
               end
            end else if (r.kind == bbc_pkg::KIND_FIND) o.status = bbc_pkg::ST_NOT_FOUND;
            else begin
               if (free_q.size() > 0) s = free_q.pop_front();
               else if (lru_q.size() > 0) begin
                  s = lru_q.pop_front(); valid_q[s] = 1'b0;
               end else o.status = bbc_pkg::ST_NO_SLOT;
               if (o.status == bbc_pkg::ST_OK) begin
                  tag_q[s] = r.bno; valid_q[s] = 1'b1;
                  if (r.kind == bbc_pkg::KIND_GET_ZERO) begin
                     dirty_q[s] = 1'b1; o.zero = 1'b1;
                  end else o.fetch = 1'b1;
                  busy_q[s] = 1'b1; o.granted = 6'(s);
               end
            end
         end
      end else if (r.kind == bbc_pkg::KIND_PUT) begin
         if (!busy_q[r.slot]) o.status = bbc_pkg::ST_NOT_BUSY;
         else begin
            if (r.mdirty || dirty_q[r.slot]) begin
               o.wb = 1'b1; o.wb_block = tag_q[r.slot];
            end
            dirty_q[r.slot] = 1'b0; busy_q[r.slot] = 1'b0;
            lru_q.push_back(int'(r.slot));
         end
      end else if (r.kind == bbc_pkg::KIND_INVALIDATE) begin
         while (lru_q.size() > 0) begin
            s = lru_q.pop_front();
            valid_q[s] = 1'b0;
            free_q.push_back(s);
            o.dropped++;
         end
      end
      return o;
   endfunction

   // ---------------- driver ----------------
   int gap_left = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            // word taken: predict it, then draw the next gap
            expected_rsps.push_back(cache_predict(pending_reqs.pop_front()));
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
         if (req_tvalid && !req_tready) begin
            // hold the word
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (!gate && pending_reqs.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tuser <= pending_reqs[0].kind;
            req_tdata <= {1'b0, pending_reqs[0].mdirty, pending_reqs[0].slot,
                          pending_reqs[0].bno};
         end else req_tvalid <= 1'b0;
      end
   end

   // ---------------- monitor ----------------
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_word_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tdata[2:0];
            got.granted  = rsp_tdata[8:3];
            got.hit      = rsp_tdata[9];
            got.fetch    = rsp_tdata[10];
            got.zero     = rsp_tdata[11];
            got.wb       = rsp_tdata[12];
            got.wb_block = rsp_tdata[44:13];
            got.dropped  = rsp_tdata[51:45];
            if (expected_rsps.size() == 0) begin
               $error("unexpected result word %h", rsp_tdata);
               fails++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $error("status exp %0d got %0d", want.status, got.status); fails++;
               end
               if (got.granted !== want.granted) begin
                  $error("granted_slot exp %0d got %0d", want.granted, got.granted);
                  fails++;
               end
               if (got.hit !== want.hit) begin
                  $error("hit exp %0d got %0d", want.hit, got.hit); fails++;
               end
               if (got.fetch !== want.fetch) begin
                  $error("fetch_request exp %0d got %0d", want.fetch, got.fetch); fails++;
               end
               if (got.zero !== want.zero) begin
                  $error("zero_request exp %0d got %0d", want.zero, got.zero); fails++;
               end
               if (got.wb !== want.wb) begin
                  $error("writeback_request exp %0d got %0d", want.wb, got.wb); fails++;
               end
               if (got.wb_block !== want.wb_block) begin
                  $error("writeback_block exp %h got %h", want.wb_block, got.wb_block);
                  fails++;
               end
               if (got.dropped !== want.dropped) begin
                  $error("dropped_count exp %0d got %0d", want.dropped, got.dropped);
                  fails++;
               end
            end
            stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   // ---------------- stimulus ----------------
   function automatic req_word_type mk(logic [2:0] k, logic [31:0] b, logic [5:0] s,
                                       logic d);
      req_word_type r;
      r.kind = k; r.bno = b; r.slot = s; r.mdirty = d;
      return r;
   endfunction

   // wait until every word has gone out and every result came back
   task automatic drain();
      while (pending_reqs.size() > 0 || req_tvalid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      drain();
      gate = 1'b1;
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      lim_block = v;
      gate = 1'b0;
   endtask

   // pick a block from a small window so hits and busy clashes happen
   function automatic logic [31:0] pick_block(logic [31:0] base);
      if ($urandom_range(0, 9) == 0) return $urandom();
      return base + $urandom_range(0, 90);
   endfunction

   task automatic random_phase(int n, logic [31:0] base);
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 99);
         if (k < 35)
            pending_reqs.push_back(mk(bbc_pkg::KIND_GET_LOAD, pick_block(base), 6'd0, 1'b0));
         else if (k < 45)
            pending_reqs.push_back(mk(bbc_pkg::KIND_GET_ZERO, pick_block(base), 6'd0, 1'b0));
         else if (k < 55)
            pending_reqs.push_back(mk(bbc_pkg::KIND_FIND, pick_block(base), 6'd0, 1'b0));
         else if (k < 95)
            pending_reqs.push_back(mk(bbc_pkg::KIND_PUT, 32'd0, 6'($urandom()),
                                      1'($urandom())));
         else if (k < 97)
            pending_reqs.push_back(mk(bbc_pkg::KIND_INVALIDATE, $urandom(),
                                      6'($urandom()), 1'($urandom())));
         else
            pending_reqs.push_back(mk(3'($urandom_range(5, 7)), $urandom(),
                                      6'($urandom()), 1'($urandom())));
      end
   endtask

   initial begin
      shadow_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, every kind, each special case
      pending_reqs.push_back(mk(bbc_pkg::KIND_PUT, 32'd0, 6'd63, 1'b1));        // not busy
      pending_reqs.push_back(mk(bbc_pkg::KIND_FIND, 32'd5, 6'd0, 1'b0));        // find miss
      pending_reqs.push_back(mk(bbc_pkg::KIND_GET_LOAD, 32'hFFFF_FFFF, 6'd0, 1'b0));
      pending_reqs.push_back(mk(bbc_pkg::KIND_GET_LOAD, 32'hFFFF_FFFE, 6'd0, 1'b0));
      pending_reqs.push_back(mk(bbc_pkg::KIND_GET_ZERO, 32'd0, 6'd0, 1'b0));
      pending_reqs.push_back(mk(bbc_pkg::KIND_GET_LOAD, 32'd0, 6'd0, 1'b0));    // busy hit
      pending_reqs.push_back(mk(bbc_pkg::KIND_PUT, 32'd0, 6'd1, 1'b0));         // writeback
      pending_reqs.push_back(mk(bbc_pkg::KIND_PUT, 32'd0, 6'd0, 1'b1));
      pending_reqs.push_back(mk(bbc_pkg::KIND_FIND, 32'd0, 6'd0, 1'b0));        // hit
      pending_reqs.push_back(mk(bbc_pkg::KIND_PUT, 32'd0, 6'd1, 1'b0));
      pending_reqs.push_back(mk(bbc_pkg::KIND_INVALIDATE, 32'd0, 6'd0, 1'b0));
      pending_reqs.push_back(mk(3'd7, 32'hFFFF_FFFF, 6'd63, 1'b1));             // unknown kind
      pending_reqs.push_back(mk(3'd5, 32'd0, 6'd0, 1'b0));
      // fill all 64 slots, then no slot left
      for (int i = 0; i < 64; i++)
         pending_reqs.push_back(mk(bbc_pkg::KIND_GET_LOAD, 32'd1000 + i, 6'd0, 1'b0));
      pending_reqs.push_back(mk(bbc_pkg::KIND_GET_LOAD, 32'd2000, 6'd0, 1'b0));
      // pause until all results are in
      drain();
      for (int i = 0; i < 64; i++)
         pending_reqs.push_back(mk(bbc_pkg::KIND_PUT, 32'd0, 6'(i), i[0]));
      pending_reqs.push_back(mk(bbc_pkg::KIND_GET_LOAD, 32'd3000, 6'd0, 1'b0)); // evict
      pending_reqs.push_back(mk(bbc_pkg::KIND_INVALIDATE, 32'd0, 6'd0, 1'b0));  // drops 63

      random_phase(400, 32'd0);
      write_limit(32'd50);
      random_phase(400, 32'd0);
      write_limit(32'd0);                                           // every block number rejected
      random_phase(100, 32'd0);
      write_limit($urandom());
      random_phase(300, 32'hFFFF_FF00);
      write_limit(32'hFFFF_FFFF);
      random_phase(400, 32'hFFFF_FF80);
      drain();
      stim_done = 1'b1;
   end

   // end of run and watchdog
   always @(posedge clock) begin
      if (stim_done) begin
         if (fails == 0 && expected_rsps.size() == 0)
            $display("block_buffer_cache_tags_test OK");
         else
            $display("block_buffer_cache_tags_test NOT OK");
         $finish;
      end else if (cycles > LIMIT) begin
         $display("block_buffer_cache_tags_test NOT OK");
         $finish;
      end
   end
endmodule

FILE: block_buffer_cache_tags.f
hw/rtl/bbc_pkg.sv
hw/rtl/bbc_slot_cell.sv
hw/rtl/bbc_order_cell.sv
hw/rtl/block_buffer_cache_tags.sv
verif/block_buffer_cache_tags_test.sv
